### hw/rtl/csf_pkg.sv
`default_nettype none
package csf_pkg;

  localparam int POS_W    = 32;
  localparam int DIFF_W   = 33;
  localparam int SQ_W     = 66;
  localparam int LEN_W    = 33;
  localparam int LENIN_W  = 31;
  localparam int RATIO_W  = 16;
  localparam int RATIO_FRAC = 14;
  localparam int QUOT_W   = 31;
  localparam int PROD_W   = 64;
  localparam int HALF_W   = 32;
  localparam int PART_W   = 63;
  localparam int FULL_W   = 95;
  localparam int MAG_SHIFT = 46;
  localparam int MAG_W    = FULL_W - MAG_SHIFT;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [RATIO_W-1:0] STRETCH_RESET  = 16'd24576;
  localparam logic [RATIO_W-1:0] COMPRESS_RESET = 16'd13107;

  localparam logic [POS_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] FORCE_MIN = 32'h8000_0000;

  typedef enum logic [0:0] {
    REG_STRETCH  = 1'b0,
    REG_COMPRESS = 1'b1
  } reg_index_t;

endpackage
`default_nettype wire

### hw/rtl/clamped_spring_force_top.sv
// Spring force unit. Each input item is one spring: two mass indices, the
// positions of both masses, a rest length and a stiffness, all Q16.16. Each
// item gives one result item: the two indices and the saturated force on
// mass A, whose negation is the force on mass B.
// Both channels use valid and stall; an item moves at a clock edge with
// valid high and stall low. The block takes one item per cycle unless a
// result is held by out_stall. The length is found by a 33-stage square
// root pipeline and the three direction components by 31-stage divider
// pipelines.
// The whole pipeline advances together. When out_stall holds a waiting
// result, the pipeline freezes and in_stall is raised in the same cycle;
// nothing is dropped or repeated.
// The clamp ratios are written through the APB port (stretch at 0, compress
// at 4). The user must write them only while no item is in flight; the block
// does not enforce it. Reset empties the pipeline, sets ratios to 1.5 and 0.8.
`default_nettype none
module clamped_spring_force_top
  import csf_pkg::*;
#(
  parameter int INDEX_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [INDEX_BITS-1:0] mass_a_index,
  input  wire logic [INDEX_BITS-1:0] mass_b_index,
  input  wire logic [POS_W-1:0]      pos_a_x,
  input  wire logic [POS_W-1:0]      pos_a_y,
  input  wire logic [POS_W-1:0]      pos_a_z,
  input  wire logic [POS_W-1:0]      pos_b_x,
  input  wire logic [POS_W-1:0]      pos_b_y,
  input  wire logic [POS_W-1:0]      pos_b_z,
  input  wire logic [LENIN_W-1:0]    rest_len,
  input  wire logic [LENIN_W-1:0]    stiffness,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [INDEX_BITS-1:0]      out_mass_a_index,
  output logic [INDEX_BITS-1:0]      out_mass_b_index,
  output logic [POS_W-1:0]           force_x,
  output logic [POS_W-1:0]           force_y,
  output logic [POS_W-1:0]           force_z,
  output logic                       saturated
);

  typedef struct packed {
    logic [INDEX_BITS-1:0]   a_idx;
    logic [INDEX_BITS-1:0]   b_idx;
    logic [2:0][DIFF_W-1:0]  dabs;
    logic [2:0]              dneg;
    logic [LENIN_W-1:0]      rest;
    logic [LENIN_W-1:0]      ks;
    logic [LEN_W-1:0]        upper;
    logic [LEN_W-1:0]        lower;
  } sq_pay_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] a_idx;
    logic [INDEX_BITS-1:0] b_idx;
    logic [PROD_W-1:0]     p;
    logic [2:0]            neg;
  } dv_pay_t;

  // Configuration registers.
  logic [RATIO_W-1:0] stretch_ratio;
  logic [RATIO_W-1:0] compress_ratio;
  reg_index_t         reg_sel;

  assign reg_sel = reg_index_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_ratio  <= STRETCH_RESET;
      compress_ratio <= COMPRESS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_STRETCH:  stretch_ratio  <= pwdata[RATIO_W-1:0];
        REG_COMPRESS: compress_ratio <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STRETCH:  prdata = {{(DATA_W-RATIO_W){1'b0}}, stretch_ratio};
      REG_COMPRESS: prdata = {{(DATA_W-RATIO_W){1'b0}}, compress_ratio};
      default:      prdata = '0;
    endcase
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // Stage 1: differences, magnitudes and clamp bounds.
  logic [2:0][POS_W-1:0] pa;
  logic [2:0][POS_W-1:0] pb;
  assign pa = {pos_a_z, pos_a_y, pos_a_x};
  assign pb = {pos_b_z, pos_b_y, pos_b_x};

  logic                   v1;
  sq_pay_t                s1;
  logic [2:0][DIFF_W-1:0] d_abs;
  logic [2:0]             d_neg;
  logic [LENIN_W+RATIO_W-1:0] up_prod;
  logic [LENIN_W+RATIO_W-1:0] lo_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [DIFF_W-1:0] d;
      d = {pa[i][POS_W-1], pa[i]} - {pb[i][POS_W-1], pb[i]};
      d_neg[i] = d[DIFF_W-1];
      d_abs[i] = d[DIFF_W-1] ? (~d + 1'b1) : d;
    end
  end

  assign up_prod = (LENIN_W+RATIO_W)'(rest_len) * (LENIN_W+RATIO_W)'(stretch_ratio);
  assign lo_prod = (LENIN_W+RATIO_W)'(rest_len) * (LENIN_W+RATIO_W)'(compress_ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.a_idx <= mass_a_index;
      s1.b_idx <= mass_b_index;
      s1.dabs  <= d_abs;
      s1.dneg  <= d_neg;
      s1.rest  <= rest_len;
      s1.ks    <= stiffness;
      s1.upper <= up_prod[LENIN_W+RATIO_W-1:RATIO_FRAC];
      s1.lower <= lo_prod[LENIN_W+RATIO_W-1:RATIO_FRAC];
    end
  end

  // Stage 2: squares.
  logic                 v2;
  sq_pay_t              s2;
  logic [2:0][SQ_W-1:0] sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= SQ_W'(s1.dabs[i]) * SQ_W'(s1.dabs[i]);
      end
    end
  end

  // Stage 3: sum of squares.
  logic            v3;
  sq_pay_t         s3;
  logic [SQ_W-1:0] sum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3   <= s2;
      sum3 <= sq2[0] + sq2[1] + sq2[2];
    end
  end

  // Length.
  logic             vr;
  logic [LEN_W-1:0] len_r;
  sq_pay_t          sr;

  csf_isqrt #(
    .PW($bits(sq_pay_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .radicand  (sum3),
    .in_pay    (s3),
    .out_valid (vr),
    .root      (len_r),
    .out_pay   (sr)
  );

  // Clamp stage: the upper bound goes first, so the lower one wins if crossed.
  logic                   vc;
  logic [LEN_W-1:0]       len_c;
  logic [LEN_W-1:0]       dmag_c;
  logic [2:0]             neg_c;
  logic [2:0][DIFF_W-1:0] dabs_c;
  logic [LENIN_W-1:0]     ks_c;
  logic [INDEX_BITS-1:0]  a_idx_c;
  logic [INDEX_BITS-1:0]  b_idx_c;
  logic [LEN_W-1:0]       clen;
  logic [LEN_W:0]         delta;

  always_comb begin
    clen = (len_r > sr.upper) ? sr.upper : len_r;
    clen = (clen < sr.lower) ? sr.lower : clen;
    delta = {1'b0, clen} - {{(LEN_W+1-LENIN_W){1'b0}}, sr.rest};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_c   <= len_r;
      dmag_c  <= delta[LEN_W] ? LEN_W'(~delta + 1'b1) : delta[LEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
        neg_c[i] <= delta[LEN_W] == sr.dneg[i];
      end
      dabs_c  <= sr.dabs;
      ks_c    <= sr.ks;
      a_idx_c <= sr.a_idx;
      b_idx_c <= sr.b_idx;
    end
  end

  // Spring term stiffness times length error.
  logic                   vp;
  dv_pay_t                sp;
  logic [LEN_W-1:0]       len_p;
  logic [2:0][DIFF_W-1:0] dabs_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp.a_idx <= a_idx_c;
      sp.b_idx <= b_idx_c;
      sp.p     <= PROD_W'(ks_c) * PROD_W'(dmag_c);
      sp.neg   <= neg_c;
      len_p    <= len_c;
      dabs_p   <= dabs_c;
    end
  end

  // Direction components, Q1.30.
  logic                   vd;
  logic [2:0][QUOT_W-1:0] u_d;
  dv_pay_t                sd;

  csf_div #(
    .PW($bits(dv_pay_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vp),
    .dabs      (dabs_p),
    .den       (len_p),
    .in_pay    (sp),
    .out_valid (vd),
    .quot      (u_d),
    .out_pay   (sd)
  );

  // Partial products of the spring term with each direction component.
  logic                   vm;
  dv_pay_t                sm;
  logic [2:0][PART_W-1:0] plo_m;
  logic [2:0][PART_W-1:0] phi_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm <= sd;
      for (int i = 0; i < 3; i++) begin
        plo_m[i] <= PART_W'(sd.p[HALF_W-1:0]) * PART_W'(u_d[i]);
        phi_m[i] <= PART_W'(sd.p[PROD_W-1:HALF_W]) * PART_W'(u_d[i]);
      end
    end
  end

  // Recombine and keep the magnitude from bit 46 up.
  logic                  va;
  dv_pay_t               sa;
  logic [2:0][MAG_W-1:0] mag_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= sm;
      for (int i = 0; i < 3; i++) begin
        logic [FULL_W-1:0] full;
        full = {phi_m[i], {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plo_m[i]};
        mag_a[i] <= full[FULL_W-1:MAG_SHIFT];
      end
    end
  end

  // Output stage: sign and saturation.
  logic [2:0][POS_W-1:0] res;
  logic [2:0]            sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
      sat[i] = 1'b0;
      if (mag_a[i] == '0) begin
        res[i] = '0;
      end else if (sa.neg[i]) begin
        if (mag_a[i] > MAG_W'(FORCE_MIN)) begin
          res[i] = FORCE_MIN;
          sat[i] = 1'b1;
        end else begin
          res[i] = ~mag_a[i][POS_W-1:0] + 1'b1;
        end
      end else begin
        if (mag_a[i] > MAG_W'(FORCE_MAX)) begin
          res[i] = FORCE_MAX;
          sat[i] = 1'b1;
        end else begin
          res[i] = mag_a[i][POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mass_a_index <= sa.a_idx;
      out_mass_b_index <= sa.b_idx;
      force_x          <= res[0];
      force_y          <= res[1];
      force_z          <= res[2];
      saturated        <= |sat;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/csf_isqrt.sv
`default_nettype none
module csf_isqrt
  import csf_pkg::*;
#(
  parameter int PW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SQ_W-1:0]   radicand,
  input  wire logic [PW-1:0]     in_pay,
  output logic                   out_valid,
  output logic [LEN_W-1:0]       root,
  output logic [PW-1:0]          out_pay
);

  localparam int RW = LEN_W + 2;

  logic              vld [LEN_W];
  logic [SQ_W-1:0]   rad [LEN_W];
  logic [RW-1:0]     rem [LEN_W];
  logic [LEN_W-1:0]  rt  [LEN_W];
  logic [PW-1:0]     pay [LEN_W];

  // One result bit per stage, most significant bit pair of the radicand first.
  for (genvar k = 0; k < LEN_W; k++) begin : g_step
    logic              s_vld;
    logic [SQ_W-1:0]   s_rad;
    logic [RW-1:0]     s_rem;
    logic [LEN_W-1:0]  s_rt;
    logic [PW-1:0]     s_pay;
    logic [RW+1:0]     cur;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign s_vld = in_valid;
      assign s_rad = radicand;
      assign s_rem = '0;
      assign s_rt  = '0;
      assign s_pay = in_pay;
    end else begin : g_next
      assign s_vld = vld[k-1];
      assign s_rad = rad[k-1];
      assign s_rem = rem[k-1];
      assign s_rt  = rt[k-1];
      assign s_pay = pay[k-1];
    end

    assign cur   = {s_rem, s_rad[SQ_W-1-2*k -: 2]};
    assign trial = {2'b00, s_rt, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k] <= s_rad;
        rem[k] <= ge ? diff[RW-1:0] : cur[RW-1:0];
        rt[k]  <= {s_rt[LEN_W-2:0], ge};
        pay[k] <= s_pay;
      end
    end
  end

  assign out_valid = vld[LEN_W-1];
  assign root      = rt[LEN_W-1];
  assign out_pay   = pay[LEN_W-1];

endmodule
`default_nettype wire

### hw/rtl/csf_div.sv
`default_nettype none
module csf_div
  import csf_pkg::*;
#(
  parameter int PW = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [2:0][DIFF_W-1:0]      dabs,
  input  wire logic [LEN_W-1:0]            den,
  input  wire logic [PW-1:0]               in_pay,
  output logic                             out_valid,
  output logic [2:0][QUOT_W-1:0]           quot,
  output logic [PW-1:0]                    out_pay
);

  logic              vld   [QUOT_W];
  logic [LEN_W-1:0]  den_s [QUOT_W];
  logic [PW-1:0]     pay   [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_ctl
    logic             s_vld;
    logic [LEN_W-1:0] s_den;
    logic [PW-1:0]    s_pay;

    if (k == 0) begin : g_first
      assign s_vld = in_valid;
      assign s_den = den;
      assign s_pay = in_pay;
    end else begin : g_next
      assign s_vld = vld[k-1];
      assign s_den = den_s[k-1];
      assign s_pay = pay[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[k] <= s_den;
        pay[k]   <= s_pay;
      end
    end
  end

  // The dividend is |d| shifted up by 30. Its top bits start as the
  // remainder, |d| bit 0 enters at the first step and zeros after that.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [LEN_W-1:0]  rem [QUOT_W];
    logic [QUOT_W-1:0] q   [QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
      logic [LEN_W-1:0]  s_rem;
      logic [QUOT_W-1:0] s_q;
      logic [LEN_W-1:0]  s_den;
      logic              s_bit;
      logic [LEN_W:0]    cur;
      logic [LEN_W:0]    diff;
      logic              ge;

      if (k == 0) begin : g_first
        assign s_rem = {1'b0, dabs[l][DIFF_W-1:1]};
        assign s_q   = '0;
        assign s_den = den;
        assign s_bit = dabs[l][0];
      end else begin : g_next
        assign s_rem = rem[k-1];
        assign s_q   = q[k-1];
        assign s_den = den_s[k-1];
        assign s_bit = 1'b0;
      end

      assign cur  = {s_rem, s_bit};
      assign diff = cur - {1'b0, s_den};
      assign ge   = cur >= {1'b0, s_den};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? diff[LEN_W-1:0] : cur[LEN_W-1:0];
          q[k]   <= {s_q[QUOT_W-2:0], ge};
        end
      end
    end

    // A zero length gives a zero direction.
    assign quot[l] = (den_s[QUOT_W-1] == '0) ? '0 : q[QUOT_W-1];
  end

  assign out_valid = vld[QUOT_W-1];
  assign out_pay   = pay[QUOT_W-1];

endmodule
`default_nettype wire

### hw/rtl/csf_checker.sv
`default_nettype none
module csf_checker
  import csf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [POS_W-1:0] force_x,
  input wire logic [POS_W-1:0] force_y,
  input wire logic [POS_W-1:0] force_z,
  input wire logic             saturated
);

  // The input side only stalls when a result is held at the output.
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output stall");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // A saturated result has at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      force_x == FORCE_MAX || force_x == FORCE_MIN ||
      force_y == FORCE_MAX || force_y == FORCE_MIN ||
      force_z == FORCE_MAX || force_z == FORCE_MIN)
    else $error("saturation flag without a limit value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind clamped_spring_force_top csf_checker u_csf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .force_x   (force_x),
  .force_y   (force_y),
  .force_z   (force_z),
  .saturated (saturated)
);
`default_nettype wire

### tb/clamped_spring_force_checker.sv
module clamped_spring_force_checker
  import csf_pkg::*;
#(
  parameter int INDEX_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [INDEX_BITS-1:0] mass_a_index,
  input  logic [INDEX_BITS-1:0] mass_b_index,
  input  logic [POS_W-1:0]      pos_a_x,
  input  logic [POS_W-1:0]      pos_a_y,
  input  logic [POS_W-1:0]      pos_a_z,
  input  logic [POS_W-1:0]      pos_b_x,
  input  logic [POS_W-1:0]      pos_b_y,
  input  logic [POS_W-1:0]      pos_b_z,
  input  logic [LENIN_W-1:0]    rest_len,
  input  logic [LENIN_W-1:0]    stiffness,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [INDEX_BITS-1:0] out_mass_a_index,
  input  logic [INDEX_BITS-1:0] out_mass_b_index,
  input  logic [POS_W-1:0]      force_x,
  input  logic [POS_W-1:0]      force_y,
  input  logic [POS_W-1:0]      force_z,
  input  logic                  saturated,
  output int                    error_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_BITS-1:0] a_idx;
    logic [INDEX_BITS-1:0] b_idx;
    logic [POS_W-1:0]      fx;
    logic [POS_W-1:0]      fy;
    logic [POS_W-1:0]      fz;
    logic                  sat;
  } force_t;

  force_t expected_forces[$];
  logic [RATIO_W-1:0] stretch_q, compress_q;

  function automatic logic [32:0] floor_sqrt(logic [65:0] v);
    logic [33:0] root;
    logic [67:0] rem, trial;
    root = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'(v[2*i +: 2]);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[32:0];
  endfunction

  function automatic force_t predict_force(
      input logic [POS_W-1:0] pa[3], input logic [POS_W-1:0] pb[3],
      input logic [LENIN_W-1:0] rest, input logic [LENIN_W-1:0] k);
    logic signed [32:0] d[3];
    logic [32:0] ad[3];
    logic [65:0] sq;
    logic [32:0] len;
    logic [47:0] upper, lower, clen, dmag;
    logic signed [48:0] delta;
    logic [127:0] p, full, mag;
    logic [63:0] u;
    logic [POS_W-1:0] comp[3];
    logic neg, sat;
    force_t r;
    sq = '0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({pa[i][31], pa[i]}) - $signed({pb[i][31], pb[i]});
      ad[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sq = sq + 66'(ad[i]) * 66'(ad[i]);
    end
    len = floor_sqrt(sq);
    upper = (48'(rest) * 48'(stretch_q)) >> RATIO_FRAC;
    lower = (48'(rest) * 48'(compress_q)) >> RATIO_FRAC;
    clen = 48'(len);
    // The lower bound is applied last, so it wins when the bounds cross.
    if (clen > upper) clen = upper;
    if (clen < lower) clen = lower;
    delta = $signed({1'b0, clen}) - $signed(49'(rest));
    dmag = delta[48] ? 48'(-delta) : 48'(delta);
    p = 128'(k) * 128'(dmag);
    for (int i = 0; i < 3; i++) begin
      u = (len != 0) ? (64'(ad[i]) << 30) / 64'(len) : 64'd0;
      full = p * 128'(u);
      mag = full >> MAG_SHIFT;
      neg = (delta[48] == d[i][32]);
      if (mag == 0) begin
        comp[i] = '0;
      end else if (neg) begin
        if (mag > 128'h8000_0000) begin
          mag = 128'h8000_0000;
          sat = 1'b1;
        end
        comp[i] = 32'(-mag);
      end else begin
        if (mag > 128'h7FFF_FFFF) begin
          mag = 128'h7FFF_FFFF;
          sat = 1'b1;
        end
        comp[i] = mag[31:0];
      end
    end
    r.a_idx = '0;
    r.b_idx = '0;
    r.fx = comp[0];
    r.fy = comp[1];
    r.fz = comp[2];
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    logic [POS_W-1:0] pa[3], pb[3];
    force_t e, got;
    int idx;
    if (rst) begin
      stretch_q <= STRETCH_RESET;
      compress_q <= COMPRESS_RESET;
      expected_forces.delete();
      error_count <= 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = int'(paddr >> 2);
        if (idx == int'(REG_STRETCH)) stretch_q <= pwdata[RATIO_W-1:0];
        else if (idx == int'(REG_COMPRESS)) compress_q <= pwdata[RATIO_W-1:0];
      end
      if (out_valid && !out_stall) begin
        got = '{out_mass_a_index, out_mass_b_index, force_x, force_y, force_z, saturated};
        if (expected_forces.size() == 0) begin
          if (error_count < 10)
            $display("%0t: unexpected result %p", $realtime, got);
          error_count <= error_count + 1;
        end else begin
          e = expected_forces.pop_front();
          if (got !== e) begin
            if (error_count < 10)
              $display("%0t: force mismatch expected %p got %p", $realtime, e, got);
            error_count <= error_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pa = '{pos_a_x, pos_a_y, pos_a_z};
        pb = '{pos_b_x, pos_b_y, pos_b_z};
        e = predict_force(pa, pb, rest_len, stiffness);
        e.a_idx = mass_a_index;
        e.b_idx = mass_b_index;
        expected_forces.push_back(e);
      end
      pending_count <= expected_forces.size();
    end
  end

endmodule

### tb/tb.sv
module tb;
  import csf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_BITS = 10;
  localparam int PIPE_LATENCY = 72;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [INDEX_BITS-1:0] mass_a_index = '0, mass_b_index = '0;
  logic [POS_W-1:0] pos_a_x = '0, pos_a_y = '0, pos_a_z = '0;
  logic [POS_W-1:0] pos_b_x = '0, pos_b_y = '0, pos_b_z = '0;
  logic [LENIN_W-1:0] rest_len = '0, stiffness = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [INDEX_BITS-1:0] out_mass_a_index, out_mass_b_index;
  logic [POS_W-1:0] force_x, force_y, force_z;
  logic saturated;
  int error_count, pending_count;

  bit sink_idle_en = 1'b1;
  bit src_idle_en = 1'b1;
  int hold_request = 0;

  always #1 clk = ~clk;

  clamped_spring_force_top #(.INDEX_BITS(INDEX_BITS)) u_top (.*);

  clamped_spring_force_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (.*);

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall per item, plus one long hold on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = sink_idle_en ? $urandom_range(10) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic reg_write(input reg_index_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_spring(input logic [POS_W-1:0] pa[3], input logic [POS_W-1:0] pb[3],
                             input logic [LENIN_W-1:0] rest, input logic [LENIN_W-1:0] k);
    int gap;
    gap = src_idle_en ? $urandom_range(10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mass_a_index <= INDEX_BITS'($urandom);
    mass_b_index <= INDEX_BITS'($urandom);
    {pos_a_x, pos_a_y, pos_a_z} <= {pa[0], pa[1], pa[2]};
    {pos_b_x, pos_b_y, pos_b_z} <= {pb[0], pb[1], pb[2]};
    rest_len <= rest;
    stiffness <= k;
    do @(posedge clk); while (in_stall);
  endtask

  // Valid drops before the next edge so the last item is not offered twice.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
  endtask

  // Mostly springs of plausible geometry, the rest raw bit noise.
  task automatic random_springs(input int count);
    logic [POS_W-1:0] pa[3], pb[3];
    logic [LENIN_W-1:0] rest, k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 7) begin
        for (int i = 0; i < 3; i++) begin
          pa[i] = POS_W'($signed(($urandom & 32'h01FF_FFFF) - 32'h0100_0000));
          pb[i] = pa[i] + POS_W'($signed(($urandom & 32'h001F_FFFF) - 32'h0010_0000));
        end
        rest = LENIN_W'($urandom_range(32'h0020_0000));
        k = ($urandom_range(4) == 0) ? LENIN_W'($urandom) : LENIN_W'($urandom_range(32'h0010_0000));
      end else begin
        for (int i = 0; i < 3; i++) begin
          pa[i] = $urandom;
          pb[i] = $urandom;
        end
        rest = LENIN_W'($urandom);
        k = LENIN_W'($urandom);
      end
      send_spring(pa, pb, rest, k);
    end
  endtask

  initial begin
    logic [POS_W-1:0] pa[3], pb[3], zero3[3];
    logic [LENIN_W-1:0] rmax;
    zero3 = '{32'd0, 32'd0, 32'd0};
    rmax = '1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed springs under the reset ratios.
    send_spring(zero3, zero3, 31'h0001_0000, 31'h0001_0000);
    send_spring(zero3, zero3, '0, rmax);
    pa = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    pb = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_spring(pa, pb, '0, rmax);
    send_spring(pb, pa, rmax, rmax);
    send_spring(pa, pb, rmax, '0);
    send_spring(pb, zero3, 31'h0001_0000, rmax);
    for (int i = 0; i < 3; i++) begin
      pa = zero3;
      pa[i] = 32'h0002_0000;
      send_spring(pa, zero3, 31'h0001_0000, 31'h0001_0000);
      send_spring(zero3, pa, 31'h0004_0000, 31'h0001_0000);
      send_spring(pa, zero3, 31'h0002_0000, 31'h0001_0000);
    end
    pa = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001};
    send_spring(pa, zero3, 31'd1, rmax);
    pa = '{32'h0003_0000, 32'hFFFC_0000, 32'h0000_0000};
    send_spring(pa, zero3, 31'h0005_0000, 31'h0002_0000);
    random_springs(300);

    // Long hold on the result side while items keep coming.
    hold_request = 400;
    random_springs(150);
    drain();

    reg_write(REG_STRETCH, 32'h0000_FFFF);
    reg_write(REG_COMPRESS, 32'h0000_0000);
    sink_idle_en = 1'b0;
    src_idle_en = 1'b0;
    random_springs(250);
    sink_idle_en = 1'b1;
    src_idle_en = 1'b1;
    drain();

    // Crossed bounds: the lower clamp must win.
    reg_write(REG_STRETCH, 32'h0000_0000);
    reg_write(REG_COMPRESS, 32'h0000_FFFF);
    pa = '{32'h0001_0000, 32'h0, 32'h0};
    send_spring(pa, zero3, 31'h0002_0000, 31'h0001_0000);
    random_springs(250);
    drain();

    reg_write(REG_STRETCH, 32'h0000_4000);
    reg_write(REG_COMPRESS, 32'h0000_4000);
    random_springs(200);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      reg_write(REG_STRETCH, $urandom);
      reg_write(REG_COMPRESS, $urandom);
      random_springs(150);
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/csf_pkg.sv
hw/rtl/csf_isqrt.sv
hw/rtl/csf_div.sv
hw/rtl/clamped_spring_force_top.sv
hw/rtl/csf_checker.sv
tb/clamped_spring_force_checker.sv
tb/tb.sv
